FILE: sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes of the sequential list engine: operation and
// status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned PosW   = 5;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LenW   = 5;

  localparam int unsigned InDataW  = 40;  // 39 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 48;  // 44 bits of fields, padded to bytes

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_GET    = 2'd1;
  localparam logic [OpW-1:0] OP_LOCATE = 2'd2;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SHIFT = 6'b000010,
    ST_PLACE = 6'b000100,
    ST_GET   = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  typedef struct packed {
    logic [StatW-1:0]       status;
    logic signed [ValW-1:0] read_value;
    logic [PosW-1:0]        found_position;
  } result_t;

endpackage

FILE: sv/sle_ram.sv
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with a registered read port.
// No reset; contents are undefined until written.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/sequential_list_engine_top.sv
// One item at a time: the store has one read and one write port, and insert
// moves and locate compares one entry per cycle through the single compare unit.
// A finished result waits in the output register while the next item is taken.
// Reset clears the entry count and control state; the store is not cleared.
// ----------------------------------------------------------------------------
// sequential_list_engine_top
// Ordered list of signed 32-bit values in a RAM with an entry count.
// Insert by position, get by position and locate by value, one entry a cycle.
// ----------------------------------------------------------------------------
module sequential_list_engine_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [1:0] op, [6:2] position, [38:7] value, [39] zero
  input  logic [sle_pkg::InDataW-1:0]      s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [1:0] status, [33:2] read_value, [38:34] found_position,
  // [43:39] list_length, [47:44] zero
  output logic [sle_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > sle_pkg::PosW) ? CW : sle_pkg::PosW) + 1;

  sle_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] pos_m1_q;
  logic signed [sle_pkg::ValW-1:0] val_q;
  sle_pkg::result_t res_q, res_d;
  sle_pkg::result_t out_q;
  logic [sle_pkg::LenW-1:0] out_len_q;
  logic out_valid_q;

  logic [sle_pkg::OpW-1:0]  in_op;
  logic [sle_pkg::PosW-1:0] in_pos;
  logic signed [sle_pkg::ValW-1:0] in_val;
  logic in_accept, out_load;

  logic [PW-1:0] in_pos_x, cnt_x, hit_x;
  logic [AW-1:0] in_pos_m1, cnt_m1;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [sle_pkg::ValW-1:0] ram_wdata, ram_rdata;

  assign in_op  = s_axis_tdata_i[1:0];
  assign in_pos = s_axis_tdata_i[6:2];
  assign in_val = s_axis_tdata_i[38:7];

  assign s_axis_tready_o = (state_q == sle_pkg::ST_IDLE);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load  = (state_q == sle_pkg::ST_DONE) && (!out_valid_q || m_axis_tready_i);

  assign in_pos_x  = PW'(in_pos);
  assign cnt_x     = PW'(count_q);
  assign hit_x     = PW'(ptr_q) + PW'(1);
  assign in_pos_m1 = AW'(in_pos_x - PW'(1));
  assign cnt_m1    = AW'(count_q - CW'(1));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q + AW'(1);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;

    unique case (state_q)
      sle_pkg::ST_IDLE: begin
        if (in_accept) begin
          res_d   = '{status: sle_pkg::STAT_OK, read_value: '0, found_position: '0};
          state_d = sle_pkg::ST_DONE;
          case (in_op)
            sle_pkg::OP_INSERT: begin
              if (in_pos == '0 || in_pos_x > cnt_x + PW'(1)) begin
                res_d.status = sle_pkg::STAT_RANGE;
              end else if (count_q == CW'(CAPACITY)) begin
                res_d.status = sle_pkg::STAT_FULL;
              end else if (in_pos_x == cnt_x + PW'(1)) begin
                state_d = sle_pkg::ST_PLACE;
              end else begin
                // move entries up, starting from the last one
                ram_re    = 1'b1;
                ram_raddr = cnt_m1;
                ptr_d     = cnt_m1;
                state_d   = sle_pkg::ST_SHIFT;
              end
            end
            sle_pkg::OP_GET: begin
              if (in_pos == '0 || in_pos_x > cnt_x) begin
                res_d.status = sle_pkg::STAT_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = in_pos_m1;
                state_d   = sle_pkg::ST_GET;
              end
            end
            sle_pkg::OP_LOCATE: begin
              if (count_q != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_d     = '0;
                state_d   = sle_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      sle_pkg::ST_SHIFT: begin
        // rdata holds entry ptr; it moves to ptr+1
        ram_we = 1'b1;
        if (ptr_q == pos_m1_q) begin
          state_d = sle_pkg::ST_PLACE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q - AW'(1);
          ptr_d     = ptr_q - AW'(1);
        end
      end
      sle_pkg::ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1_q;
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
        state_d   = sle_pkg::ST_DONE;
      end
      sle_pkg::ST_GET: begin
        res_d.read_value = ram_rdata;
        state_d          = sle_pkg::ST_DONE;
      end
      sle_pkg::ST_SCAN: begin
        if (ram_rdata == val_q) begin
          res_d.found_position = hit_x[sle_pkg::PosW-1:0];
          state_d              = sle_pkg::ST_DONE;
        end else if (hit_x == cnt_x) begin
          state_d = sle_pkg::ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end
      sle_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = sle_pkg::ST_IDLE;
        end
      end
      default: state_d = sle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sle_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    res_q <= res_d;
    if (in_accept) begin
      pos_m1_q <= in_pos_m1;
      val_q    <= in_val;
    end
    if (out_load) begin
      out_q     <= res_q;
      out_len_q <= cnt_x[sle_pkg::LenW-1:0];
    end
  end

  sle_ram #(
    .Width(sle_pkg::ValW),
    .Depth(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_len_q, out_q.found_position,
                            out_q.read_value, out_q.status};

endmodule
